// File: hdl/sobel_x_pkg.sv
package sobel_x_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int MIN_SIZE   = 3;

   localparam int PIXEL_W   = 8;
   localparam int SIZE_W    = 10;
   localparam int COORD_W   = 9;
   localparam int GRAD_W    = 11;
   localparam int CSR_IDX_W = 2;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);

   typedef logic [PIXEL_W-1:0]   pixel_type;
   typedef logic [SIZE_W-1:0]    size_type;
   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic signed [GRAD_W-1:0] grad_type;

   localparam csr_index_type CSR_IMAGE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_IMAGE_HEIGHT = csr_index_type'(1);

   localparam size_type SIZE_RESET = size_type'(512);

   typedef struct packed {
      logic      accept;
      addr_type  col;
      pixel_type pixel;
   } lb_req_type;

   function automatic size_type clamp_size(size_type v, size_type hi);
      size_type r;
      if (v < size_type'(MIN_SIZE)) begin
         r = size_type'(MIN_SIZE);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: hdl/sobel_x_req_if.sv
interface sobel_x_req_if;
   logic                  valid;
   logic                  ready;
   sobel_x_pkg::pixel_type pixel;
   logic                  frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

// File: hdl/sobel_x_rsp_if.sv
interface sobel_x_rsp_if;
   logic                  valid;
   logic                  ready;
   sobel_x_pkg::grad_type  gradient;
   sobel_x_pkg::coord_type center_row;
   sobel_x_pkg::coord_type center_col;
   logic                  frame_last;

   modport source (output valid, output gradient, output center_row, output center_col,
                   output frame_last, input ready);
   modport sink (input valid, input gradient, input center_row, input center_col,
                 input frame_last, output ready);
endinterface

// File: hdl/sobel_x_csr_if.sv
interface sobel_x_csr_if;
   logic                      valid;
   logic                      ready;
   sobel_x_pkg::csr_index_type index;
   sobel_x_pkg::size_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/sobel_x_3x3_gradient.sv
// Horizontal Sobel gradient over a raster pixel stream.
// req_bus carries one pixel per word in raster order; frame_start marks row 0,
// column 0 of a frame. rsp_bus carries one word per interior pixel: the signed
// gradient, the window centre row and column, and frame_last on the frame's
// final interior result. Border pixels produce no rsp word.
// csr_bus writes image_width (index 0) and image_height (index 1); values are
// clamped to 3..512. Write only while no pixel is in flight.
// Throughput: one pixel per cycle while rsp_bus is not stalled and the line stores
// are not being cleared. A pixel passes the line store read and input register,
// then the result register, before its result shows on rsp_bus.
// After reset the two 512-entry line stores are zeroed, one entry per cycle:
// req_bus.ready stays low until the clear ends, csr writes are taken throughout.
// A stalled rsp_bus holds its word; the input register takes pixels until it
// holds one with a result, after which req_bus.ready follows rsp_bus.ready.
module sobel_x_3x3_gradient (
   input logic            clock,
   input logic            reset,
   sobel_x_req_if.sink    req_bus,
   sobel_x_rsp_if.source  rsp_bus,
   sobel_x_csr_if.sink    csr_bus
);

   sobel_x_pkg::size_type  width_ff, width_in;
   sobel_x_pkg::size_type  height_ff, height_in;
   sobel_x_pkg::coord_type col_ff, col_in;
   sobel_x_pkg::coord_type row_ff, row_in;

   logic                  s1_valid_ff, s1_valid_in;
   sobel_x_pkg::pixel_type s1_pixel_ff, s1_pixel_in;
   logic                  s1_emit_ff, s1_emit_in;
   logic                  s1_last_ff, s1_last_in;
   sobel_x_pkg::coord_type s1_crow_ff, s1_crow_in;
   sobel_x_pkg::coord_type s1_ccol_ff, s1_ccol_in;

   sobel_x_pkg::pixel_type win1_ff [3];
   sobel_x_pkg::pixel_type win1_in [3];
   sobel_x_pkg::pixel_type win2_ff [3];
   sobel_x_pkg::pixel_type win2_in [3];

   logic                  rsp_valid_ff, rsp_valid_in;
   sobel_x_pkg::grad_type  rsp_grad_ff, rsp_grad_in;
   sobel_x_pkg::coord_type rsp_row_ff, rsp_row_in;
   sobel_x_pkg::coord_type rsp_col_ff, rsp_col_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  s1_adv;
   logic                  lb_busy;
   sobel_x_pkg::lb_req_type lb_req;
   sobel_x_pkg::pixel_type above1;
   sobel_x_pkg::pixel_type above2;
   sobel_x_pkg::size_type  w_eff;
   sobel_x_pkg::size_type  h_eff;
   sobel_x_pkg::coord_type col_cur;
   sobel_x_pkg::coord_type row_cur;
   logic                  col_end;
   logic                  row_end;
   logic [sobel_x_pkg::GRAD_W-1:0] pos_sum;
   logic [sobel_x_pkg::GRAD_W-1:0] neg_sum;

   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && req_bus.ready;
   assign s1_adv = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !lb_busy && (!s1_valid_ff || s1_adv);

   assign w_eff = sobel_x_pkg::clamp_size(width_ff,
                                          sobel_x_pkg::size_type'(sobel_x_pkg::MAX_WIDTH));
   assign h_eff = sobel_x_pkg::clamp_size(height_ff,
                                          sobel_x_pkg::size_type'(sobel_x_pkg::MAX_HEIGHT));
   assign col_cur = req_bus.frame_start ? '0 : col_ff;
   assign row_cur = req_bus.frame_start ? '0 : row_ff;
   assign col_end = {1'b0, col_cur} >= (w_eff - sobel_x_pkg::size_type'(1));
   assign row_end = {1'b0, row_cur} >= (h_eff - sobel_x_pkg::size_type'(1));

   assign lb_req.accept = accept;
   assign lb_req.col    = sobel_x_pkg::addr_type'(col_cur);
   assign lb_req.pixel  = req_bus.pixel;

   sobel_x_line_buf u_line_buf (
      .clock       (clock),
      .reset       (reset),
      .req         (lb_req),
      .stage_valid (s1_valid_ff),
      .above1      (above1),
      .above2      (above2),
      .busy        (lb_busy)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            sobel_x_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_bus.data;
            sobel_x_pkg::CSR_IMAGE_HEIGHT: height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_cur + sobel_x_pkg::coord_type'(1);
         end else begin
            col_in = col_cur + sobel_x_pkg::coord_type'(1);
            row_in = row_cur;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_emit_in  = s1_emit_ff;
      s1_last_in  = s1_last_ff;
      s1_crow_in  = s1_crow_ff;
      s1_ccol_in  = s1_ccol_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pixel_in = req_bus.pixel;
         s1_emit_in  = (row_cur >= sobel_x_pkg::coord_type'(2))
                    && (col_cur >= sobel_x_pkg::coord_type'(2));
         s1_last_in  = row_end && col_end;
         s1_crow_in  = row_cur - sobel_x_pkg::coord_type'(1);
         s1_ccol_in  = col_cur - sobel_x_pkg::coord_type'(1);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      win1_in = win1_ff;
      win2_in = win2_ff;
      if (s1_adv) begin
         win1_in    = win2_ff;
         win2_in[0] = above2;
         win2_in[1] = above1;
         win2_in[2] = s1_pixel_ff;
      end
   end

   always_comb begin
      pos_sum = {3'b0, win1_ff[0]} + {2'b0, win1_ff[1], 1'b0} + {3'b0, win1_ff[2]};
      neg_sum = {3'b0, above2} + {2'b0, above1, 1'b0} + {3'b0, s1_pixel_ff};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_grad_in  = rsp_grad_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_grad_in  = sobel_x_pkg::grad_type'(pos_sum - neg_sum);
         rsp_row_in   = s1_crow_ff;
         rsp_col_in   = s1_ccol_ff;
         rsp_last_in  = s1_last_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= sobel_x_pkg::SIZE_RESET;
         height_ff    <= sobel_x_pkg::SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= s1_pixel_in;
      s1_emit_ff  <= s1_emit_in;
      s1_last_ff  <= s1_last_in;
      s1_crow_ff  <= s1_crow_in;
      s1_ccol_ff  <= s1_ccol_in;
      win1_ff     <= win1_in;
      win2_ff     <= win2_in;
      rsp_grad_ff <= rsp_grad_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.gradient   = rsp_grad_ff;
   assign rsp_bus.center_row = rsp_row_ff;
   assign rsp_bus.center_col = rsp_col_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule

// File: hdl/sobel_x_line_buf.sv
module sobel_x_line_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  sobel_x_pkg::lb_req_type req,
   input  logic                   stage_valid,
   output sobel_x_pkg::pixel_type  above1,
   output sobel_x_pkg::pixel_type  above2,
   output logic                   busy
);

   sobel_x_pkg::pixel_type upper_mem  [sobel_x_pkg::MAX_WIDTH];
   sobel_x_pkg::pixel_type middle_mem [sobel_x_pkg::MAX_WIDTH];

   logic                  clear_active_ff, clear_active_in;
   sobel_x_pkg::addr_type  clear_addr_ff, clear_addr_in;
   sobel_x_pkg::addr_type  addr_ff, addr_in;
   logic                  hit_ff, hit_in;
   sobel_x_pkg::pixel_type fwd_ff, fwd_in;
   sobel_x_pkg::pixel_type up_rd_ff;
   sobel_x_pkg::pixel_type mid_rd_ff;

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + sobel_x_pkg::addr_type'(1);
         if (clear_addr_ff == sobel_x_pkg::addr_type'(sobel_x_pkg::MAX_WIDTH - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   // forward the upper-store word written in the same cycle as a read of that entry
   always_comb begin
      addr_in = addr_ff;
      hit_in  = hit_ff;
      fwd_in  = fwd_ff;
      if (req.accept) begin
         addr_in = req.col;
         hit_in  = stage_valid && (addr_ff == req.col);
         fwd_in  = mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      hit_ff  <= hit_in;
      fwd_ff  <= fwd_in;
   end

   always_ff @(posedge clock) begin
      if (clear_active_ff) begin
         middle_mem[clear_addr_ff] <= '0;
      end else if (req.accept) begin
         middle_mem[req.col] <= req.pixel;
      end
      if (req.accept) begin
         mid_rd_ff <= middle_mem[req.col];
      end
   end

   always_ff @(posedge clock) begin
      if (clear_active_ff) begin
         upper_mem[clear_addr_ff] <= '0;
      end else if (stage_valid) begin
         upper_mem[addr_ff] <= mid_rd_ff;
      end
      if (req.accept) begin
         up_rd_ff <= upper_mem[req.col];
      end
   end

   assign above1 = mid_rd_ff;
   assign above2 = hit_ff ? fwd_ff : up_rd_ff;
   assign busy   = clear_active_ff;

endmodule

// File: hdl/sobel_x_checker.sv
module sobel_x_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input sobel_x_pkg::grad_type   rsp_gradient,
   input sobel_x_pkg::coord_type  rsp_center_row,
   input sobel_x_pkg::coord_type  rsp_center_col
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gradient))
      else $error("rsp word dropped or changed while stalled");

   a_grad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gradient >= -11'sd1020) && (rsp_gradient <= 11'sd1020))
      else $error("gradient out of range");

   a_center_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_row != '0) && (rsp_center_col != '0))
      else $error("border pixel emitted");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("pixel taken during line store clear");

endmodule

bind sobel_x_3x3_gradient sobel_x_checker u_sobel_x_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_gradient   (rsp_bus.gradient),
   .rsp_center_row (rsp_bus.center_row),
   .rsp_center_col (rsp_bus.center_col)
);
